[hw/rtl/ring_buffer_deque_top_defines.svh]
// Assertion macros shared by the ring buffer deque checker.
`ifndef RING_BUFFER_DEQUE_TOP_DEFINES_SVH
`define RING_BUFFER_DEQUE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RBD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbd checker: same-cycle property failed");

// Check that cons holds in the cycle after ante.
`define RBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbd checker: next-cycle property failed");

`endif

[hw/rtl/rbd_pkg.sv]
// Types, operation codes and status codes for the ring buffer deque.
`default_nettype none

package rbd_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int TOKEN_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_data;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Response stage between the controller and the top level.
  typedef struct packed {
    logic                done;
    logic                rd_sel;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;
    logic [STATUS_W-1:0] status;
  } resp_t;

endpackage

`default_nettype wire

[hw/rtl/ring_buffer_deque_top.sv]
// Top level of the ring buffer deque: controller plus ring store RAM.
`default_nettype none

// Ring buffer deque of DEPTH token words. The block takes one item in every
// clock cycle: busy stays low, so an item is accepted whenever start is high.
// Each item yields exactly one result, in the cycle after acceptance, shown on
// result for that single cycle with done high; the receiver cannot stall and
// must take the result in that cycle. The result is registered, like the read
// port of the ring store RAM, which serves read_at. Head
// pointer and entry count live in flip-flops and are updated at acceptance,
// and a push writes the RAM at the same edge, so a read_at in the very next
// cycle already sees the new entry. Clear only resets pointer and count; the
// stored words stay in the RAM but are no longer reachable. read_data is zero
// for every result except a successful read_at.
module ring_buffer_deque_top #(
  parameter int DEPTH       = rbd_pkg::DEPTH_DEF,
  parameter int TOKEN_WIDTH = rbd_pkg::TOKEN_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rbd_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output rbd_pkg::result_t result
);
  import rbd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                   accept;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [TOKEN_WIDTH-1:0] wdata;
  logic [TOKEN_WIDTH-1:0] rdata;
  resp_t                  resp;

  // Every operation completes without a wait state: never hold off an item.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rbd_ctrl #(
    .DEPTH       (DEPTH),
    .TOKEN_WIDTH (TOKEN_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .resp   (resp)
  );

  rbd_ram #(
    .WIDTH (TOKEN_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Drive the result from the response stage; pass RAM data only on a hit.
  assign done             = resp.done;
  assign result.read_data = resp.rd_sel ? VALUE_W'(rdata) : '0;
  assign result.count     = resp.count;
  assign result.is_empty  = resp.is_empty;
  assign result.is_full   = resp.is_full;
  assign result.status    = resp.status;

endmodule

`default_nettype wire

[hw/rtl/rbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rbd_ram #(
  parameter int WIDTH = rbd_pkg::TOKEN_WIDTH_DEF,
  parameter int DEPTH = rbd_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/rbd_ctrl.sv]
// Head pointer, entry count and RAM address logic of the ring buffer deque.
`default_nettype none

module rbd_ctrl #(
  parameter int DEPTH       = rbd_pkg::DEPTH_DEF,
  parameter int TOKEN_WIDTH = rbd_pkg::TOKEN_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  rbd_pkg::cmd_t          cmd,
  output logic                   we,
  output logic [AW-1:0]          waddr,
  output logic [TOKEN_WIDTH-1:0] wdata,
  output logic [AW-1:0]          raddr,
  output rbd_pkg::resp_t         resp
);
  import rbd_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int XW   = (CW > COUNT_W) ? CW : COUNT_W;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [STATUS_W-1:0] status;
  logic                rd_sel;
  logic                full;
  logic                empty;
  logic                in_range;
  logic [CMPW-1:0]     pos_x;
  logic [CMPW-1:0]     cnt_x;
  logic [XW-1:0]       cnt_out;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       head_inc;

  // Ring index of base + off, with off never above DEPTH.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pos_x    = CMPW'(cmd.position);
  assign cnt_x    = CMPW'(count);
  assign in_range = (pos_x < cnt_x);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = wrap_add(head, CW'(1));
  assign wdata    = TOKEN_WIDTH'(cmd.value);
  assign raddr    = wrap_add(head, pos_x[CW-1:0]);

  always_comb begin
    head_next  = head;
    count_next = count;
    we         = 1'b0;
    waddr      = head_dec;
    status     = ST_OK;
    rd_sel     = 1'b0;
    unique case (cmd.op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          head_next  = head_dec;
          count_next = count + CW'(1);
          we         = accept;
        end
      end
      OP_PUSH_BACK: begin
        waddr = wrap_add(head, count);
        if (full) begin
          status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
          we         = accept;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      OP_READ_AT: begin
        if (in_range) begin
          rd_sel = 1'b1;
        end else begin
          status = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign cnt_out = XW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      resp.done <= 1'b0;
    end else begin
      resp.done <= accept;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
    end
    // Result fields; qualified by resp.done.
    resp.rd_sel   <= rd_sel;
    resp.count    <= cnt_out[COUNT_W-1:0];
    resp.is_empty <= (count_next == '0);
    resp.is_full  <= (count_next == CW'(DEPTH));
    resp.status   <= status;
  end

endmodule

`default_nettype wire

[hw/rtl/rbd_checker.sv]
// Port-level checker for the ring buffer deque, bound to the top level.
`default_nettype none
`include "ring_buffer_deque_top_defines.svh"

module rbd_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rbd_pkg::result_t result
);
  import rbd_pkg::*;

  `RBD_ASSERT_NEXT(a_done_after_accept, start && !busy, done)
  `RBD_ASSERT_NEXT(a_no_done_unasked, !(start && !busy), !done)
  `RBD_ASSERT_SAME(a_empty_matches_count, done, result.is_empty == (result.count == '0))
  `RBD_ASSERT_SAME(a_reject_no_data, done && (result.status != ST_OK), result.read_data == '0)
  `RBD_ASSERT_SAME(a_full_reject_is_full, done && (result.status == ST_FULL), result.is_full)

endmodule

bind ring_buffer_deque_top rbd_checker u_rbd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
